### rtl/core/wswa_pkg.sv
package wswa_pkg;

  localparam int DATA_W            = 16;
  localparam int PPU_W             = 8;
  localparam int QUO_W             = 16;
  localparam int STEP_W            = 4;
  localparam int LONG_WINDOW_DEF   = 30;
  localparam int SHORT_WINDOW_DEF  = 15;

  localparam logic [PPU_W-1:0]  PPU_RESET = 8'd6;
  localparam logic [QUO_W-1:0]  QUO_SAT   = 16'hFFFF;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_POS,
    S_WRITE,
    S_SCAN,
    S_SCAN_END,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  // Order in which the four quotients run through the shared divider
  typedef enum logic [1:0] {
    DIV_NOW   = 2'd0,
    DIV_SHORT = 2'd1,
    DIV_LONG  = 2'd2,
    DIV_GUST  = 2'd3
  } div_sel_t;

endpackage

### rtl/core/wswa_ring.sv
module wswa_ring import wswa_pkg::*; #(
  parameter int DEPTH  = LONG_WINDOW_DEF,
  parameter int ADDR_W = $clog2(LONG_WINDOW_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] mem_q;
  logic              valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

### rtl/core/wswa_div.sv
module wswa_div import wswa_pkg::*; #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // num < den * 2^QUO_W, so the upper part of num starts below den.
  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  q;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, q[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(num >> QUO_W);
      q     <= num[QUO_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      q   <= {q[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo = q;

endmodule

### rtl/core/wind_speed_window_averager_core.sv
// Wind speed window averager. Each input word is one interval's anemometer
// pulse count; each produces one output word with the current speed, the
// mean over the newest SHORT_WINDOW counts, the mean over the whole ring of
// LONG_WINDOW counts, and the gust (largest count in the ring), all divided
// by pulses_per_unit and rounded half up. Means divide by the number of
// counts seen so far, up to the window size. With pulses_per_unit at zero
// all four speeds read 65535. The history lives in a single-port-read ring
// memory cleared by per-entry valid bits at reset, so the block takes words
// right after reset. Each word runs through two reads of the old samples,
// one write, a scan of the whole ring for the maximum at one entry per
// cycle, then four 16-step divisions on one shared serial divider. The
// input is taken again as soon as the result sits in the output register;
// the block waits only if that register is still full and out_stall is
// high when the next result is ready. Write pulses_per_unit only while the
// block is idle.
module wind_speed_window_averager_core import wswa_pkg::*; #(
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] pulse_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] speed_now,
  output logic [DATA_W-1:0] speed_short_mean,
  output logic [DATA_W-1:0] speed_long_mean,
  output logic [DATA_W-1:0] gust_speed,
  input  logic              cfg_wr_en,
  input  logic [PPU_W-1:0]  cfg_wr_data
);

  // Short window wider than the ring behaves as the ring
  localparam int EFF_SHORT = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
  localparam int POS_W     = $clog2(LONG_WINDOW);
  localparam int LFILL_W   = $clog2(LONG_WINDOW + 1);
  localparam int SFILL_W   = $clog2(EFF_SHORT + 1);
  localparam int LSUM_W    = DATA_W + $clog2(LONG_WINDOW);
  localparam int SSUM_W    = DATA_W + $clog2(EFF_SHORT);
  localparam int NUM_W     = LSUM_W + 1;
  localparam int DEN_W     = LFILL_W + PPU_W;

  localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(LONG_WINDOW - 1);
  localparam logic [POS_W:0]     SHORT_OFS  = (POS_W + 1)'(EFF_SHORT);
  localparam logic [POS_W:0]     RING_OFS   = (POS_W + 1)'(LONG_WINDOW - EFF_SHORT);
  localparam logic [SFILL_W-1:0] SFILL_MAX  = SFILL_W'(EFF_SHORT);
  localparam logic [LFILL_W-1:0] LFILL_MAX  = LFILL_W'(LONG_WINDOW);

  state_t state, state_next;

  logic [PPU_W-1:0]   ppu;
  logic [DATA_W-1:0]  sample;
  logic [POS_W-1:0]   pos;
  logic [SSUM_W-1:0]  short_sum;
  logic [LSUM_W-1:0]  long_sum;
  logic [SFILL_W-1:0] short_fill;
  logic [LFILL_W-1:0] long_fill;
  logic [DATA_W-1:0]  old_short;
  logic [DATA_W-1:0]  gust;
  logic [POS_W-1:0]   scan_idx;
  logic               scan_vld;
  logic [DEN_W-1:0]   den_short;
  logic [DEN_W-1:0]   den_long;
  div_sel_t           sel;
  logic [QUO_W-1:0]   res [4];

  logic [POS_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;
  logic               wr_en;
  logic [POS_W:0]     old_pos_ext;
  logic [POS_W-1:0]   old_short_pos;

  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_quo;
  logic               in_acc;
  logic               out_free;

  // Slot that drops out of the short window when pos is overwritten
  assign old_pos_ext   = ({1'b0, pos} >= SHORT_OFS) ? ({1'b0, pos} - SHORT_OFS)
                                                    : ({1'b0, pos} + RING_OFS);
  assign old_short_pos = old_pos_ext[POS_W-1:0];

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wr_en    = (state == S_WRITE);

  wswa_ring #(
    .DEPTH  (LONG_WINDOW),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (sample)
  );

  wswa_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Divider operands; numerator carries the half-divisor for round half up
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (sel)
      DIV_NOW: begin
        div_den = DEN_W'(ppu);
        div_num = NUM_W'(sample) + NUM_W'(ppu >> 1);
      end
      DIV_SHORT: begin
        div_den = den_short;
        div_num = NUM_W'(short_sum) + NUM_W'(den_short >> 1);
      end
      DIV_LONG: begin
        div_den = den_long;
        div_num = NUM_W'(long_sum) + NUM_W'(den_long >> 1);
      end
      default: begin
        div_den = DEN_W'(ppu);
        div_num = NUM_W'(gust) + NUM_W'(ppu >> 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_addr    = pos;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = old_short_pos;
        if (in_valid) begin
          state_next = S_RD_POS;
        end
      end
      S_RD_POS: begin
        rd_addr    = pos;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = scan_idx;
        if (scan_idx == POS_LAST) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (sel == DIV_GUST) ? S_OUT : S_DIV_START;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ppu        <= PPU_RESET;
      pos        <= '0;
      short_sum  <= '0;
      long_sum   <= '0;
      short_fill <= '0;
      long_fill  <= '0;
      scan_idx   <= '0;
      scan_vld   <= 1'b0;
      sel        <= DIV_NOW;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ppu <= cfg_wr_data;
      end
      scan_vld <= (state == S_SCAN);
      if (state == S_WRITE) begin
        // rd_data holds the sample leaving the long window
        short_sum <= short_sum - SSUM_W'(old_short) + SSUM_W'(sample);
        long_sum  <= long_sum - LSUM_W'(rd_data) + LSUM_W'(sample);
        pos       <= (pos == POS_LAST) ? '0 : pos + 1'b1;
        if (short_fill != SFILL_MAX) begin
          short_fill <= short_fill + 1'b1;
        end
        if (long_fill != LFILL_MAX) begin
          long_fill <= long_fill + 1'b1;
        end
        scan_idx <= '0;
      end
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (state == S_MUL) begin
        sel <= DIV_NOW;
      end
      if ((state == S_DIV_WAIT) && div_done) begin
        sel <= div_sel_t'(sel + 2'd1);
      end
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= pulse_count;
    end
    if (state == S_RD_POS) begin
      old_short <= rd_data;
    end
    if (state == S_WRITE) begin
      gust <= '0;
    end else if (scan_vld && (rd_data > gust)) begin
      gust <= rd_data;
    end
    if (state == S_MUL) begin
      den_short <= DEN_W'(short_fill) * DEN_W'(ppu);
      den_long  <= DEN_W'(long_fill) * DEN_W'(ppu);
    end
    if ((state == S_DIV_WAIT) && div_done) begin
      res[sel] <= div_quo;
    end
    if ((state == S_OUT) && out_free) begin
      if (ppu == '0) begin
        speed_now        <= QUO_SAT;
        speed_short_mean <= QUO_SAT;
        speed_long_mean  <= QUO_SAT;
        gust_speed       <= QUO_SAT;
      end else begin
        speed_now        <= res[DIV_NOW];
        speed_short_mean <= res[DIV_SHORT];
        speed_long_mean  <= res[DIV_LONG];
        gust_speed       <= res[DIV_GUST];
      end
    end
  end

endmodule
